### hdl/mpm_pkg.sv
// shared types and constants of the multi-pattern presence matcher
package mpm_pkg;

	localparam logic [1:0] CMD_PAT   = 2'd0;
	localparam logic [1:0] CMD_BUILD = 2'd1;
	localparam logic [1:0] CMD_TEXT  = 2'd2;
	localparam logic [1:0] CMD_QUERY = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_BADCH   = 3'd2;
	localparam logic [2:0] ST_PHASE   = 3'd3;
	localparam logic [2:0] ST_UNKNOWN = 3'd4;

	localparam logic [7:0] LETTER_A = 8'h61;

	typedef enum logic [2:0] {
		OP_ERR   = 3'd0,
		OP_LOAD  = 3'd1,
		OP_BUILD = 3'd2,
		OP_SCAN  = 3'd3,
		OP_QUERY = 3'd4
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] status;
		logic [7:0] letter;
		logic       last;
		logic [9:0] pnum;
	} entry_t;

endpackage

### hdl/mpm_ram.sv
// generic single-write, single-read ram with registered read data
module mpm_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/mpm_front.sv
// front end: accepts commands, checks phase and character, classifies into operations
module mpm_front import mpm_pkg::*; #(
	parameter int ALPHABET = 26
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] ch,
	input  logic       end_of_pattern,
	input  logic [9:0] pattern_number,
	input  logic       q_full,
	output logic       push,
	output entry_t     push_entry
);

	logic       built_q;
	logic       ch_ok;
	logic [7:0] ofs;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign ofs      = ch - LETTER_A;
	assign ch_ok    = (ch >= LETTER_A) && (9'(ofs) < 9'(ALPHABET));

	always_comb begin
		push_entry.op     = OP_ERR;
		push_entry.status = ST_OK;
		push_entry.letter = ofs;
		push_entry.last   = end_of_pattern;
		push_entry.pnum   = pattern_number;
		unique case (cmd)
			CMD_PAT: begin
				if (built_q) begin
					push_entry.status = ST_PHASE;
				end else if (!ch_ok) begin
					push_entry.status = ST_BADCH;
				end else begin
					push_entry.op = OP_LOAD;
				end
			end
			CMD_BUILD: begin
				if (built_q) begin
					push_entry.status = ST_PHASE;
				end else begin
					push_entry.op = OP_BUILD;
				end
			end
			CMD_TEXT: begin
				if (!built_q) begin
					push_entry.status = ST_PHASE;
				end else if (!ch_ok) begin
					push_entry.status = ST_BADCH;
				end else begin
					push_entry.op = OP_SCAN;
				end
			end
			default: begin
				push_entry.op = OP_QUERY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			built_q <= 1'b0;
		end else if (push && cmd == CMD_BUILD) begin
			built_q <= 1'b1;
		end
	end

endmodule

### hdl/mpm_fifo.sv
// two-entry queue between front and back end
module mpm_fifo import mpm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   not_empty,
	output entry_t head
);

	entry_t     mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### hdl/mpm_back.sv
// back end: trie, link build, text scan and query over the automaton memories
module mpm_back import mpm_pkg::*; #(
	parameter int MAX_NODES    = 4096,
	parameter int MAX_PATTERNS = 1024,
	parameter int ALPHABET     = 26
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_not_empty,
	input  entry_t     q_head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic       found,
	output logic [9:0] assigned_number
);

	localparam int NW  = $clog2(MAX_NODES);
	localparam int PW  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
	localparam int LW  = $clog2(ALPHABET);
	localparam int TD  = MAX_NODES * ALPHABET;
	localparam int AW  = $clog2(TD);
	localparam int QW  = (PW + 1 > 10) ? PW + 1 : 10;

	typedef enum logic [15:0] {
		S_CLR     = 16'h0001,
		S_IDLE    = 16'h0002,
		S_LD_CHK  = 16'h0004,
		S_LD_FIN  = 16'h0008,
		S_B_HEAD  = 16'h0010,
		S_B_U     = 16'h0020,
		S_B_FU    = 16'h0040,
		S_B_RD1   = 16'h0080,
		S_B_RD2   = 16'h0100,
		S_B_WR    = 16'h0200,
		S_SC_NODE = 16'h0400,
		S_SC_CHK  = 16'h0800,
		S_SC_MK   = 16'h1000,
		S_Q_PEN   = 16'h2000,
		S_Q_MK    = 16'h4000,
		S_DONE    = 16'h8000
	} state_t;

	state_t          state_q;
	logic [NW:0]     node_cnt_q;
	logic [PW:0]     pat_cnt_q;
	logic [NW-1:0]   cursor_q;
	logic [NW-1:0]   scan_q;
	logic [NW-1:0]   clr_node_q;
	logic [LW-1:0]   k_q;
	logic            clr_ld_q;
	logic [LW-1:0]   c_q;
	logic            last_q;
	logic [NW-1:0]   nxt_q;
	logic [NW-1:0]   u_q;
	logic [NW-1:0]   fu_q;
	logic [NW-1:0]   v_q;
	logic [NW-1:0]   p_q;
	logic [NW:0]     head_q;
	logic [NW:0]     tail_q;
	logic [2:0]      pst_q;
	logic            pfound_q;
	logic [9:0]      passign_q;

	logic            tt_we;
	logic [AW-1:0]   tt_waddr;
	logic [AW-1:0]   tt_raddr;
	logic [NW-1:0]   tt_wdata;
	logic [NW-1:0]   tt_rd;
	logic            fl_we;
	logic [NW-1:0]   fl_waddr;
	logic [NW-1:0]   fl_wdata;
	logic [NW-1:0]   fl_raddr;
	logic [NW-1:0]   fl_rd;
	logic            mk_we;
	logic [NW-1:0]   mk_waddr;
	logic            mk_wdata;
	logic [NW-1:0]   mk_raddr;
	logic            mk_rd;
	logic            pen_we;
	logic [PW-1:0]   pen_raddr;
	logic [NW-1:0]   pen_rd;
	logic            bq_we;
	logic [NW-1:0]   bq_waddr;
	logic [NW-1:0]   bq_wdata;
	logic [NW-1:0]   bq_rd;
	logic [LW-1:0]   hl;
	logic            unknown;

	function automatic logic [AW-1:0] slot(input logic [NW-1:0] node, input logic [LW-1:0] c);
		slot = AW'(node) * AW'(ALPHABET) + AW'(c);
	endfunction

	assign hl      = q_head.letter[LW-1:0];
	assign unknown = QW'(q_head.pnum) >= QW'(pat_cnt_q);
	assign pop     = (state_q == S_IDLE) && q_not_empty;

	always_comb begin
		tt_we     = 1'b0;
		tt_waddr  = slot(clr_node_q, k_q);
		tt_wdata  = '0;
		tt_raddr  = slot(u_q, c_q);
		fl_we     = 1'b0;
		fl_waddr  = v_q;
		fl_wdata  = (u_q == '0) ? '0 : tt_rd;
		fl_raddr  = p_q;
		mk_we     = 1'b0;
		mk_waddr  = p_q;
		mk_wdata  = 1'b1;
		mk_raddr  = p_q;
		pen_we    = 1'b0;
		pen_raddr = PW'(q_head.pnum);
		bq_we     = 1'b0;
		bq_waddr  = tail_q[NW-1:0];
		bq_wdata  = v_q;
		unique case (state_q)
			S_CLR: begin
				tt_we = 1'b1;
			end
			S_IDLE: begin
				if (q_head.op == OP_SCAN) begin
					tt_raddr = slot(scan_q, hl);
				end else begin
					tt_raddr = slot(cursor_q, hl);
				end
				if (pop && q_head.op == OP_BUILD) begin
					fl_we    = 1'b1;
					fl_waddr = '0;
					fl_wdata = '0;
					bq_we    = 1'b1;
					bq_waddr = '0;
					bq_wdata = '0;
				end
			end
			S_LD_CHK: begin
				if (tt_rd == '0 && node_cnt_q != (NW+1)'(MAX_NODES)
						&& !(last_q && pat_cnt_q == (PW+1)'(MAX_PATTERNS))) begin
					tt_we    = 1'b1;
					tt_waddr = slot(cursor_q, c_q);
					tt_wdata = node_cnt_q[NW-1:0];
					mk_we    = 1'b1;
					mk_waddr = node_cnt_q[NW-1:0];
					mk_wdata = 1'b0;
				end
			end
			S_LD_FIN: begin
				pen_we = last_q;
			end
			S_B_U: begin
				fl_raddr = bq_rd;
			end
			S_B_RD2: begin
				tt_raddr = slot(fu_q, c_q);
			end
			S_B_WR: begin
				if (v_q != '0) begin
					fl_we = 1'b1;
					bq_we = 1'b1;
				end else if (u_q != '0) begin
					tt_we    = 1'b1;
					tt_waddr = slot(u_q, c_q);
					tt_wdata = tt_rd;
				end
			end
			S_SC_MK: begin
				mk_we = !mk_rd;
			end
			S_Q_PEN: begin
				mk_raddr = pen_rd;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				c_q    <= hl;
				last_q <= q_head.last;
			end
			S_B_U: begin
				u_q <= bq_rd;
			end
			S_B_FU: begin
				fu_q <= fl_rd;
				c_q  <= '0;
			end
			S_B_RD2: begin
				v_q <= tt_rd;
			end
			S_B_WR: begin
				c_q <= c_q + LW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLR;
			node_cnt_q      <= (NW+1)'(1);
			pat_cnt_q       <= '0;
			cursor_q        <= '0;
			scan_q          <= '0;
			clr_node_q      <= '0;
			k_q             <= '0;
			clr_ld_q        <= 1'b0;
			nxt_q           <= '0;
			p_q             <= '0;
			head_q          <= '0;
			tail_q          <= '0;
			pst_q           <= ST_OK;
			pfound_q        <= 1'b0;
			passign_q       <= '0;
			out_valid       <= 1'b0;
			status          <= ST_OK;
			found           <= 1'b0;
			assigned_number <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					if (k_q == LW'(ALPHABET - 1)) begin
						k_q     <= '0;
						state_q <= clr_ld_q ? S_LD_FIN : S_IDLE;
					end else begin
						k_q <= k_q + LW'(1);
					end
				end
				S_IDLE: begin
					pfound_q  <= 1'b0;
					passign_q <= '0;
					if (q_not_empty) begin
						pst_q <= (q_head.op == OP_QUERY && unknown) ? ST_UNKNOWN
							: q_head.status;
						case (q_head.op)
							OP_LOAD: state_q <= S_LD_CHK;
							OP_BUILD: begin
								head_q  <= '0;
								tail_q  <= (NW+1)'(1);
								state_q <= S_B_HEAD;
							end
							OP_SCAN: state_q <= S_SC_NODE;
							OP_QUERY: state_q <= unknown ? S_DONE : S_Q_PEN;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_LD_CHK: begin
					if (tt_rd == '0 && node_cnt_q == (NW+1)'(MAX_NODES)) begin
						pst_q   <= ST_FULL;
						state_q <= S_DONE;
					end else if (last_q && pat_cnt_q == (PW+1)'(MAX_PATTERNS)) begin
						pst_q   <= ST_FULL;
						state_q <= S_DONE;
					end else if (tt_rd == '0) begin
						nxt_q      <= node_cnt_q[NW-1:0];
						node_cnt_q <= node_cnt_q + (NW+1)'(1);
						clr_node_q <= node_cnt_q[NW-1:0];
						clr_ld_q   <= 1'b1;
						k_q        <= '0;
						state_q    <= S_CLR;
					end else begin
						nxt_q   <= tt_rd;
						state_q <= S_LD_FIN;
					end
				end
				S_LD_FIN: begin
					if (last_q) begin
						passign_q <= 10'(pat_cnt_q);
						pat_cnt_q <= pat_cnt_q + (PW+1)'(1);
						cursor_q  <= '0;
					end else begin
						cursor_q <= nxt_q;
					end
					state_q <= S_DONE;
				end
				S_B_HEAD: begin
					state_q <= (head_q == tail_q) ? S_DONE : S_B_U;
				end
				S_B_U: begin
					head_q  <= head_q + (NW+1)'(1);
					state_q <= S_B_FU;
				end
				S_B_FU: begin
					state_q <= S_B_RD1;
				end
				S_B_RD1: begin
					state_q <= S_B_RD2;
				end
				S_B_RD2: begin
					state_q <= S_B_WR;
				end
				S_B_WR: begin
					if (v_q != '0) begin
						tail_q <= tail_q + (NW+1)'(1);
					end
					state_q <= (c_q == LW'(ALPHABET - 1)) ? S_B_HEAD : S_B_RD1;
				end
				S_SC_NODE: begin
					scan_q  <= tt_rd;
					p_q     <= tt_rd;
					state_q <= S_SC_CHK;
				end
				S_SC_CHK: begin
					state_q <= (p_q == '0) ? S_DONE : S_SC_MK;
				end
				S_SC_MK: begin
					if (mk_rd) begin
						state_q <= S_DONE;
					end else begin
						p_q     <= fl_rd;
						state_q <= S_SC_CHK;
					end
				end
				S_Q_PEN: begin
					state_q <= S_Q_MK;
				end
				S_Q_MK: begin
					pfound_q <= mk_rd;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid       <= 1'b1;
						status          <= pst_q;
						found           <= pfound_q;
						assigned_number <= passign_q;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	mpm_ram #(.WIDTH(NW), .DEPTH(TD)) u_tt (
		.clk(clk), .we(tt_we), .waddr(tt_waddr), .wdata(tt_wdata),
		.raddr(tt_raddr), .rdata(tt_rd)
	);

	mpm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fl (
		.clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
		.raddr(fl_raddr), .rdata(fl_rd)
	);

	mpm_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_mk (
		.clk(clk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
		.raddr(mk_raddr), .rdata(mk_rd)
	);

	mpm_ram #(.WIDTH(NW), .DEPTH(MAX_PATTERNS)) u_pen (
		.clk(clk), .we(pen_we), .waddr(pat_cnt_q[PW-1:0]), .wdata(nxt_q),
		.raddr(pen_raddr), .rdata(pen_rd)
	);

	mpm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_bq (
		.clk(clk), .we(bq_we), .waddr(bq_waddr), .wdata(bq_wdata),
		.raddr(head_q[NW-1:0]), .rdata(bq_rd)
	);

endmodule

### hdl/multi_pattern_presence_matcher.sv
// top level of the multi-pattern presence matcher
// Aho-Corasick matcher over the letters 'a' onward. One result per transaction. After reset
// the root row of the transition memory is cleared before the back end takes the first
// command. The front end takes a command per cycle into a two-entry queue while it is not
// full; the back end runs one command at a time against single-port-read memories: a pattern
// character that allocates a node also clears that node's row; a text character steps the
// scan state and walks its failure chain, marking each newly reached node, up to the root or
// an already marked node; a query reads the pattern's end node and then its mark; an error or
// an unknown pattern goes straight to the result; the build visits every node of the trie.
module multi_pattern_presence_matcher import mpm_pkg::*; #(
	parameter int MAX_NODES    = 4096,
	parameter int MAX_PATTERNS = 1024,
	parameter int ALPHABET     = 26
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] ch,
	input  logic       end_of_pattern,
	input  logic [9:0] pattern_number,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic       found,
	output logic [9:0] assigned_number
);

	logic   q_full;
	logic   push;
	entry_t push_entry;
	logic   pop;
	logic   q_not_empty;
	entry_t q_head;

	mpm_front #(.ALPHABET(ALPHABET)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .ch(ch), .end_of_pattern(end_of_pattern),
		.pattern_number(pattern_number), .q_full(q_full), .push(push),
		.push_entry(push_entry)
	);

	mpm_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_entry(push_entry),
		.full(q_full), .pop(pop), .not_empty(q_not_empty), .head(q_head)
	);

	mpm_back #(
		.MAX_NODES(MAX_NODES), .MAX_PATTERNS(MAX_PATTERNS), .ALPHABET(ALPHABET)
	) u_back (
		.clk(clk), .arst_n(arst_n), .q_not_empty(q_not_empty), .q_head(q_head),
		.pop(pop), .out_valid(out_valid), .out_stall(out_stall), .status(status),
		.found(found), .assigned_number(assigned_number)
	);

endmodule

### hdl/mpm_checker.sv
// port-level checker for the multi-pattern presence matcher and its bind
module mpm_checker import mpm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] status,
	input logic       found,
	input logic [9:0] assigned_number
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled result dropped or changed");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == ST_OK && assigned_number == '0)
		else $error("found set on failed or non-query transaction");

	a_assign_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && assigned_number != '0 |-> status == ST_OK)
		else $error("pattern number given on error");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_FULL || status == ST_BADCH
			|| status == ST_PHASE || status == ST_UNKNOWN)
		else $error("status code out of range");

endmodule

bind multi_pattern_presence_matcher mpm_checker u_mpm_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.status(status), .found(found), .assigned_number(assigned_number)
);

### test/mpm_match_checker.sv
// transaction monitor, automaton predictor and result comparison for the matcher
`timescale 1ns / 100ps

module mpm_match_checker import mpm_pkg::*; #(
	parameter int MAX_NODES    = 4096,
	parameter int MAX_PATTERNS = 1024,
	parameter int ALPHABET     = 26
) (
	input  logic       clk,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] ch,
	input  logic       end_of_pattern,
	input  logic [9:0] pattern_number,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [2:0] status,
	input  logic       found,
	input  logic [9:0] assigned_number,
	output int         mismatches,
	output int         awaited
);

	typedef struct packed {
		logic [2:0] status;
		logic       found;
		logic [9:0] number;
	} match_result_t;

	match_result_t awaited_results[$];

	int  goto_next [MAX_NODES*ALPHABET];
	int  fail_to   [MAX_NODES];
	bit  seen      [MAX_NODES];
	int  end_node  [MAX_PATTERNS];
	int  bfs_order [MAX_NODES];
	int  nodes_used;
	int  patterns_used;
	int  load_at;
	int  text_at;
	bit  automaton_ready;

	initial begin
		foreach (goto_next[i]) goto_next[i] = 0;
		foreach (fail_to[i]) begin
			fail_to[i] = 0;
			seen[i] = 0;
		end
		nodes_used = 1;
		patterns_used = 0;
		load_at = 0;
		text_at = 0;
		automaton_ready = 0;
		mismatches = 0;
	end

	assign awaited = awaited_results.size();

	function automatic bit is_letter(logic [7:0] b);
		return b >= LETTER_A && int'(b) - int'(LETTER_A) < ALPHABET;
	endfunction

	function automatic void complete_automaton();
		int head, tail, u, v;
		head = 0;
		tail = 0;
		fail_to[0] = 0;
		bfs_order[tail++] = 0;
		while (head < tail) begin
			u = bfs_order[head++];
			for (int c = 0; c < ALPHABET; c++) begin
				v = goto_next[u*ALPHABET + c];
				if (v != 0 && tail < MAX_NODES) begin
					fail_to[v] = (u == 0) ? 0 : goto_next[fail_to[u]*ALPHABET + c];
					bfs_order[tail++] = v;
				end
			end
			if (u != 0)
				for (int c = 0; c < ALPHABET; c++)
					if (goto_next[u*ALPHABET + c] == 0)
						goto_next[u*ALPHABET + c] = goto_next[fail_to[u]*ALPHABET + c];
		end
		automaton_ready = 1;
	endfunction

	function automatic match_result_t predict_match_result(logic [1:0] op, logic [7:0] b,
			logic last, logic [9:0] pnum);
		match_result_t r;
		int c, nxt, p;
		r = '0;
		c = int'(b) - int'(LETTER_A);
		case (op)
			CMD_PAT: begin
				if (automaton_ready) begin
					r.status = ST_PHASE;
				end else if (!is_letter(b)) begin
					r.status = ST_BADCH;
				end else begin
					nxt = goto_next[load_at*ALPHABET + c];
					if ((nxt == 0 && nodes_used >= MAX_NODES) ||
							(last && patterns_used >= MAX_PATTERNS)) begin
						r.status = ST_FULL;
					end else begin
						if (nxt == 0) begin
							nxt = nodes_used;
							goto_next[load_at*ALPHABET + c] = nxt;
							nodes_used++;
						end
						if (last) begin
							end_node[patterns_used] = nxt;
							r.number = 10'(patterns_used);
							patterns_used++;
							load_at = 0;
						end else begin
							load_at = nxt;
						end
					end
				end
			end
			CMD_BUILD: begin
				if (automaton_ready) r.status = ST_PHASE;
				else complete_automaton();
			end
			CMD_TEXT: begin
				if (!automaton_ready) begin
					r.status = ST_PHASE;
				end else if (!is_letter(b)) begin
					r.status = ST_BADCH;
				end else begin
					text_at = goto_next[text_at*ALPHABET + c];
					p = text_at;
					while (p != 0 && !seen[p]) begin
						seen[p] = 1;
						p = fail_to[p];
					end
				end
			end
			default: begin
				if (pnum >= patterns_used) r.status = ST_UNKNOWN;
				else r.found = seen[end_node[pnum]];
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		match_result_t want;
		if (in_valid && !in_stall)
			awaited_results.insert(awaited_results.size(),
				predict_match_result(cmd, ch, end_of_pattern, pattern_number));
		if (out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected transaction status %0d found %0d number %0d",
					$time, status, found, assigned_number);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				if (want.status !== status || want.found !== found ||
						want.number !== assigned_number) begin
					$display("%0t: expected status %0d found %0d number %0d, got %0d %0d %0d",
						$time, want.status, want.found, want.number,
						status, found, assigned_number);
					mismatches++;
				end
			end
		end
	end

endmodule

### test/multi_pattern_presence_matcher_tb.sv
// stimulus and verdict for the multi-pattern presence matcher
`timescale 1ns / 100ps

module multi_pattern_presence_matcher_tb;
	import mpm_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_stall;
	logic [1:0] cmd = CMD_QUERY;
	logic [7:0] ch = LETTER_A;
	logic       end_of_pattern = 0;
	logic [9:0] pattern_number = 0;
	logic       out_valid;
	logic       out_stall = 0;
	logic [2:0] status;
	logic       found;
	logic [9:0] assigned_number;
	int         mismatches;
	int         awaited;
	int         cycles = 0;
	int         burst_left = 0;

	always #5 clk = ~clk;

	multi_pattern_presence_matcher dut (.*);

	mpm_match_checker checker_i (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("multi_pattern_presence_matcher_tb NOT OK");
			$finish;
		end
	end

	// receiver stall pattern: calm, choppy and long-hold stretches
	always @(posedge clk) begin
		case ((cycles / 500) % 3)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 1) == 1);
			default: out_stall <= ($urandom_range(0, 15) < 12);
		endcase
	end

	task automatic send_item(logic [1:0] op, logic [7:0] b, logic last, logic [9:0] pnum);
		int gap;
		in_valid <= 1;
		cmd <= op;
		ch <= b;
		end_of_pattern <= last;
		pattern_number <= pnum;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 30);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic logic [7:0] pick_letter(int span);
		if ($urandom_range(0, 9) == 0) return 8'(LETTER_A + $urandom_range(0, 25));
		return 8'(LETTER_A + $urandom_range(0, span - 1));
	endfunction

	function automatic logic [7:0] pick_noise_byte();
		case ($urandom_range(0, 3))
			0: return LETTER_A - 8'd1;
			1: return LETTER_A + 8'd26;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [9:0] pick_pnum();
		return 10'($urandom_range(0, 1023));
	endfunction

	task automatic send_noise(logic [1:0] op);
		send_item(op, pick_noise_byte(), 1'($urandom_range(0, 1)), pick_pnum());
	endtask

	initial begin
		int len;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_item(CMD_TEXT, LETTER_A, 0, 0);
		send_item(CMD_QUERY, 8'h00, 1, 0);
		send_item(CMD_QUERY, 8'hFF, 0, 10'h3FF);
		send_item(CMD_PAT, LETTER_A - 8'd1, 0, 0);
		send_item(CMD_PAT, LETTER_A + 8'd26, 1, 0);
		send_item(CMD_PAT, 8'h00, 0, 10'h3FF);
		send_item(CMD_PAT, 8'hFF, 1, 0);
		send_item(CMD_PAT, LETTER_A + 8'd25, 1, 10'h2AA);
		send_item(CMD_PAT, LETTER_A, 0, 0);
		send_item(CMD_PAT, LETTER_A + 8'd1, 1, 0);
		send_item(CMD_QUERY, 8'h55, 1, 0);
		send_item(CMD_QUERY, 8'hAA, 0, 1);
		send_item(CMD_QUERY, 8'h00, 0, 2);

		// well-formed patterns over a narrow alphabet, with some noise
		for (int i = 0; i < 150; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_noise(($urandom_range(0, 1) == 1) ? CMD_PAT : CMD_TEXT);
				send_noise(CMD_QUERY);
			end
			len = $urandom_range(1, 5);
			for (int k = 0; k < len; k++)
				send_item(CMD_PAT, pick_letter(4), k == len - 1, pick_pnum());
		end
		for (int i = 0; i < 20; i++)
			send_item(CMD_QUERY, 8'($urandom_range(0, 255)), 0, pick_pnum());

		send_item(CMD_BUILD, 8'h00, 0, 0);
		send_item(CMD_BUILD, 8'hFF, 1, 10'h3FF);
		send_item(CMD_PAT, LETTER_A, 1, 0);
		send_item(CMD_TEXT, LETTER_A - 8'd1, 0, 0);
		send_item(CMD_TEXT, LETTER_A + 8'd26, 0, 0);

		for (int i = 0; i < 800; i++) begin
			case ($urandom_range(0, 19))
				0: send_noise(CMD_TEXT);
				1: send_noise(CMD_PAT);
				2: send_item(CMD_BUILD, 8'($urandom_range(0, 255)), 0, 0);
				3, 4, 5, 6: send_item(CMD_QUERY, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), pick_pnum());
				default: send_item(CMD_TEXT, pick_letter(4), 1'($urandom_range(0, 1)),
					pick_pnum());
			endcase
		end
		for (int i = 0; i < 200; i++)
			send_item(CMD_QUERY, 8'h00, 0, 10'(i));
		in_valid <= 0;

		while (awaited != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && awaited == 0) begin
			$display("multi_pattern_presence_matcher_tb OK");
		end else begin
			$display("multi_pattern_presence_matcher_tb NOT OK");
		end
		$finish;
	end

endmodule
